>>> rtl/peak_finder_2d_row_bisection_top_assert.svh
// assertion macros for the 2d peak finder top level
// expects clk and rst_n in the scope of the including module
`ifndef PEAK_FINDER_2D_ROW_BISECTION_TOP_ASSERT_SVH
`define PEAK_FINDER_2D_ROW_BISECTION_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PF2D_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pf2d same-cycle check failed");

// next-cycle implication, checked outside reset
`define PF2D_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pf2d next-cycle check failed");

`endif

>>> rtl/pf2d_pkg.sv
// shared types and constants for the 2d peak finder
// no dependencies
`default_nettype none

package pf2d_pkg;

    localparam int CFG_W  = 7;
    localparam int DATA_W = 32;
    localparam int OUT_W  = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_END,
        ST_UP,
        ST_DN,
        ST_DECIDE,
        ST_FINISH
    } pf2d_state_t;

    // effective sizes and write strobe from the register block
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic             wr;
    } pf2d_cfg_t;

    typedef struct packed {
        logic load_wr;
        logic set_mid;
        logic scan_issue;
        logic up_issue;
        logic dn_issue;
        logic up_capture;
        logic decide;
        logic set_fail;
        logic publish;
    } pf2d_cmd_t;

    typedef struct packed {
        logic load_last;
        logic range_empty;
        logic scan_last;
        logic is_peak;
        logic out_free;
    } pf2d_sts_t;

endpackage

`default_nettype wire

>>> rtl/pf2d_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pf2d_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/pf2d_regs.sv
// apb-style configuration registers: row and column counts
// depends on pf2d_pkg
`default_nettype none

module pf2d_regs
    import pf2d_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output pf2d_cfg_t   cfg
);

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] col_count_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_W'(1);
            col_count_reg <= CFG_W'(1);
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_ROW_COUNT: row_count_reg <= pwdata[CFG_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ROW_COUNT: prdata = {{(32-CFG_W){1'b0}}, row_count_reg};
            REG_COL_COUNT: prdata = {{(32-CFG_W){1'b0}}, col_count_reg};
            default:       prdata = '0;
        endcase
    end

    // a zero count is used as one, anything above the array size is clamped
    always_comb
    begin
        if (row_count_reg == '0)
            cfg.rows = CFG_W'(1);
        else if (int'(row_count_reg) > MAX_ROWS)
            cfg.rows = CFG_W'(MAX_ROWS);
        else
            cfg.rows = row_count_reg;

        if (col_count_reg == '0)
            cfg.cols = CFG_W'(1);
        else if (int'(col_count_reg) > MAX_COLS)
            cfg.cols = CFG_W'(MAX_COLS);
        else
            cfg.cols = col_count_reg;

        cfg.wr = wr_en;
    end

endmodule

`default_nettype wire

>>> rtl/pf2d_ctrl.sv
// controller state machine: load, row bisection steps and result hand-off
// depends on pf2d_pkg
`default_nettype none

module pf2d_ctrl
    import pf2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  pf2d_sts_t sts,
    output pf2d_cmd_t cmd
);

    pf2d_state_t state_reg;
    pf2d_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall    = 1'b0;
                cmd.load_wr = in_valid;
                if (in_valid && sts.load_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.range_empty)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.set_mid = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                    state_next = ST_SCAN_END;
            end
            // last element of the row is compared here
            ST_SCAN_END:
            begin
                state_next = ST_UP;
            end
            ST_UP:
            begin
                cmd.up_issue = 1'b1;
                state_next   = ST_DN;
            end
            ST_DN:
            begin
                cmd.dn_issue   = 1'b1;
                cmd.up_capture = 1'b1;
                state_next     = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.is_peak)
                    state_next = ST_FINISH;
                else
                    state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/pf2d_dp.sv
// datapath: matrix store, load counters, row scan, bisection bounds, output register
// depends on pf2d_pkg and pf2d_ram
`default_nettype none

module pf2d_dp
    import pf2d_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pf2d_cfg_t                cfg,
    input  pf2d_cmd_t                cmd,
    output pf2d_sts_t                sts,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [OUT_W-1:0]         peak_row,
    output logic [OUT_W-1:0]         peak_col,
    output logic                     found
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] COLS_STEP = AW'(MAX_COLS);

    // load position
    logic [CFG_W-1:0] ld_col_reg, ld_col_next;
    logic [CFG_W-1:0] ld_row_reg, ld_row_next;
    logic [AW-1:0]    ld_base_reg, ld_base_next;

    // bisection bounds, high may drop to minus one
    logic signed [CFG_W:0] lo_reg, lo_next;
    logic signed [CFG_W:0] hi_reg, hi_next;

    logic [CFG_W-1:0] mid_reg, mid_next;
    logic [AW-1:0]    mid_base_reg, mid_base_next;

    // row scan
    logic [CFG_W-1:0]  scan_col_reg, scan_col_next;
    logic              pend_reg, pend_next;
    logic [CFG_W-1:0]  pend_col_reg, pend_col_next;
    logic [CFG_W-1:0]  best_col_reg, best_col_next;
    logic [DATA_W-1:0] best_val_reg, best_val_next;
    logic [DATA_W-1:0] up_val_reg, up_val_next;

    // result
    logic [OUT_W-1:0] res_row_reg, res_row_next;
    logic [OUT_W-1:0] res_col_reg, res_col_next;
    logic             res_found_reg, res_found_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] peak_row_reg, peak_row_next;
    logic [OUT_W-1:0] peak_col_reg, peak_col_next;
    logic             found_reg, found_next;

    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              load_last;
    logic              row_end;
    logic signed [CFG_W:0] mid_wide;
    logic              has_up;
    logic              has_dn;
    logic              above_up;
    logic              above_dn;
    logic              is_peak;
    logic              go_dn;

    pf2d_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.load_wr),
        .wr_addr(ld_base_reg + AW'(ld_col_reg)),
        .wr_data(value),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign row_end   = (ld_col_reg == cfg.cols - CFG_W'(1));
    assign load_last = row_end && (ld_row_reg == cfg.rows - CFG_W'(1));
    assign mid_wide  = lo_reg + ((hi_reg - lo_reg) >>> 1);

    // neighbour checks use the previous-cycle up read and the current dn read
    assign has_up   = (mid_reg != '0);
    assign has_dn   = ({1'b0, mid_reg} + (CFG_W+1)'(1)) < {1'b0, cfg.rows};
    assign above_up = !has_up || ($signed(up_val_reg) < $signed(best_val_reg));
    assign above_dn = !has_dn || ($signed(rd_data) < $signed(best_val_reg));
    assign is_peak  = above_up && above_dn;
    assign go_dn    = has_dn && ($signed(best_val_reg) < $signed(rd_data));

    always_comb
    begin
        if (cmd.up_issue)
            rd_addr = mid_base_reg - COLS_STEP + AW'(best_col_reg);
        else if (cmd.dn_issue)
            rd_addr = mid_base_reg + COLS_STEP + AW'(best_col_reg);
        else
            rd_addr = mid_base_reg + AW'(scan_col_reg);
    end

    always_comb
    begin
        ld_col_next    = ld_col_reg;
        ld_row_next    = ld_row_reg;
        ld_base_next   = ld_base_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        mid_base_next  = mid_base_reg;
        scan_col_next  = scan_col_reg;
        pend_next      = 1'b0;
        pend_col_next  = pend_col_reg;
        best_col_next  = best_col_reg;
        best_val_next  = best_val_reg;
        up_val_next    = up_val_reg;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && out_stall;
        peak_row_next  = peak_row_reg;
        peak_col_next  = peak_col_reg;
        found_next     = found_reg;

        if (cfg.wr)
        begin
            ld_col_next  = '0;
            ld_row_next  = '0;
            ld_base_next = '0;
        end
        else if (cmd.load_wr)
        begin
            if (load_last)
            begin
                ld_col_next  = '0;
                ld_row_next  = '0;
                ld_base_next = '0;
                lo_next      = '0;
                hi_next      = $signed({1'b0, cfg.rows}) - (CFG_W+1)'(1);
            end
            else if (row_end)
            begin
                ld_col_next  = '0;
                ld_row_next  = ld_row_reg + CFG_W'(1);
                ld_base_next = ld_base_reg + COLS_STEP;
            end
            else
            begin
                ld_col_next = ld_col_reg + CFG_W'(1);
            end
        end

        if (cmd.set_mid)
        begin
            mid_next      = mid_wide[CFG_W-1:0];
            mid_base_next = AW'(mid_wide[CFG_W-1:0]) * COLS_STEP;
            scan_col_next = '0;
        end

        if (cmd.scan_issue)
        begin
            pend_next     = 1'b1;
            pend_col_next = scan_col_reg;
            scan_col_next = scan_col_reg + CFG_W'(1);
        end

        // first maximum wins: replace only on strictly greater
        if (pend_reg && ((pend_col_reg == '0) || ($signed(best_val_reg) < $signed(rd_data))))
        begin
            best_val_next = rd_data;
            best_col_next = pend_col_reg;
        end

        if (cmd.up_capture)
            up_val_next = rd_data;

        if (cmd.decide)
        begin
            if (is_peak)
            begin
                res_row_next   = mid_reg[OUT_W-1:0];
                res_col_next   = best_col_reg[OUT_W-1:0];
                res_found_next = 1'b1;
            end
            else if (go_dn)
                lo_next = $signed({1'b0, mid_reg}) + (CFG_W+1)'(1);
            else
                hi_next = $signed({1'b0, mid_reg}) - (CFG_W+1)'(1);
        end

        if (cmd.set_fail)
        begin
            res_row_next   = '0;
            res_col_next   = '0;
            res_found_next = 1'b0;
        end

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
            peak_row_next  = res_row_reg;
            peak_col_next  = res_col_reg;
            found_next     = res_found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_col_reg    <= '0;
            ld_row_reg    <= '0;
            ld_base_reg   <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            scan_col_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ld_col_reg    <= ld_col_next;
            ld_row_reg    <= ld_row_next;
            ld_base_reg   <= ld_base_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            scan_col_reg  <= scan_col_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        mid_base_reg  <= mid_base_next;
        pend_col_reg  <= pend_col_next;
        best_col_reg  <= best_col_next;
        best_val_reg  <= best_val_next;
        up_val_reg    <= up_val_next;
        res_row_reg   <= res_row_next;
        res_col_reg   <= res_col_next;
        res_found_reg <= res_found_next;
        peak_row_reg  <= peak_row_next;
        peak_col_reg  <= peak_col_next;
        found_reg     <= found_next;
    end

    always_comb
    begin
        sts.load_last   = load_last;
        sts.range_empty = (lo_reg > hi_reg);
        sts.scan_last   = (scan_col_reg == cfg.cols - CFG_W'(1));
        sts.is_peak     = is_peak;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign peak_row  = peak_row_reg;
    assign peak_col  = peak_col_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

>>> rtl/peak_finder_2d_row_bisection_top.sv
// load: rows*cols accepted transactions, one per cycle, then a search of
// at most floor(log2(rows))+1 passes (check, row scan, up read, down read, decide), then finish
// throughput: one matrix at a time; row scans read the single ram read port one column a cycle
// reset: counts return to one, load position and bounds to zero, output empty;
// the matrix ram is not cleared and holds no valid bits
`default_nettype none

`include "peak_finder_2d_row_bisection_top_assert.svh"

module peak_finder_2d_row_bisection_top
    import pf2d_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [OUT_W-1:0]         peak_row,
    output logic [OUT_W-1:0]         peak_col,
    output logic                     found
);

    pf2d_cfg_t cfg;
    pf2d_cmd_t cmd;
    pf2d_sts_t sts;

    pf2d_regs #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    pf2d_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    pf2d_dp #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .value    (value),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .peak_row (peak_row),
        .peak_col (peak_col),
        .found    (found)
    );

    // a failed search reports position zero
    `PF2D_ASSERT_IMP(a_fail_zero, out_valid && !found, (peak_row == '0) && (peak_col == '0))
    // a found peak lies inside the configured rows
    `PF2D_ASSERT_IMP(a_row_range, out_valid && found, peak_row < cfg.rows)
    // results appear only after the search, never during a load
    `PF2D_ASSERT_IMP(a_pub_busy, $rose(out_valid), $past(in_stall))

endmodule

`default_nettype wire
